// File: rtl/assert_macros.svh
// Assertion helpers for the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtsd assertion failed");

// Next-cycle implication, disabled during reset
`define MTSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtsd assertion failed");

`endif

// File: rtl/mtsd_pkg.sv
package mtsd_pkg;

   // event types and codes
   localparam logic [15:0] TYPE_SYN    = 16'd0;
   localparam logic [15:0] TYPE_ABS    = 16'd3;
   localparam logic [15:0] CODE_REPORT = 16'h0000;
   localparam logic [15:0] CODE_SLOT   = 16'h002f;
   localparam logic [15:0] CODE_TRACK  = 16'h0039;
   localparam logic [15:0] CODE_POSX   = 16'h0035;
   localparam logic [15:0] CODE_POSY   = 16'h0036;

   // tracking id that means the finger has lifted
   localparam logic [31:0] TRACK_RELEASE = 32'hffff_ffff;

   // per-slot pending marks
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PRESS = 2'd1;
   localparam logic [1:0] PEND_MOVE  = 2'd2;

   // reported touch kinds
   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_MOVE    = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   // register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam int SIZE_W  = 13;
   localparam int POS_W   = 16;
   localparam int FINGER_W = 3;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd800;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

   // one decoded event, ev_type in the lowest bits as on the bus
   typedef struct packed {
      logic [31:0] ev_value;
      logic [15:0] ev_code;
      logic [15:0] ev_type;
   } event_type;

   // report produced by the slot logic
   typedef struct packed {
      logic                hit;
      logic [1:0]          kind;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [FINGER_W-1:0] finger;
   } report_type;

endpackage

// File: rtl/multitouch_slot_event_decoder_core.sv
// Multitouch slot event decoder, one event per transfer on req_, touch reports on rsp_.
// A report passes the input register and then the output register before it is offered on rsp_.
// Throughput: one event per cycle; only a stalled rsp_ holding a report stops req_.
// The slot read, scaling multiply and slot update sit between the input and output registers.
// Reset (synchronous, active high) clears all slots, the current slot and both channels,
// and loads screen width 800 and height 480.
`include "assert_macros.svh"

module multitouch_slot_event_decoder_core #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // event stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // ev_type[15:0], ev_code[31:16], ev_value[63:32]
   // report stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pos_x[15:0], pos_y[31:16], finger_index[34:32], zero pad
   output logic [1:0]  rsp_tuser,   // touch_kind[1:0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

   logic                         in_valid_ff;
   mtsd_pkg::event_type          in_evt_ff;
   logic                         rsp_valid_ff;
   mtsd_pkg::report_type         rsp_ff;
   logic [mtsd_pkg::SIZE_W-1:0]  width_ff, height_ff;
   mtsd_pkg::report_type         report;
   logic                         advance;

   // an event moves on unless it has a report and the output is blocked
   assign advance    = in_valid_ff && (!report.hit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mtsd_pkg::WIDTH_RESET;
         height_ff <= mtsd_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mtsd_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
            mtsd_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_evt_ff <= mtsd_pkg::event_type'(req_tdata);
      end
   end

   mtsd_slot_state #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_slot_state (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .evt    (in_evt_ff),
      .x_size (width_ff),
      .y_size (height_ff),
      .report (report)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && report.hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && report.hit) begin
         rsp_ff <= report;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'b00000, rsp_ff.finger, rsp_ff.pos_y, rsp_ff.pos_x};

   // checks
   `MTSD_ASSERT_NEXT(a_report_lands, clock, reset, advance && report.hit, rsp_valid_ff)
   `MTSD_ASSERT_NOW(a_stall_needs_item, clock, reset, !req_tready, in_valid_ff && report.hit)
   `MTSD_ASSERT_NOW(a_kind_defined, clock, reset, rsp_valid_ff,
                    rsp_ff.kind != mtsd_pkg::KIND_UNUSED)

endmodule

// File: rtl/mtsd_scale.sv
// Raw position times screen size, divided by 4096, clamped to 0..65535
module mtsd_scale (
   input  logic [31:0]                value,
   input  logic [mtsd_pkg::SIZE_W-1:0] size,
   output logic [mtsd_pkg::POS_W-1:0]  scaled
);

   localparam int PROD_W = 32 + mtsd_pkg::SIZE_W + 1;

   logic signed [PROD_W-1:0] prod;
   logic        [PROD_W-13:0] quot;

   // signed value by unsigned size
   assign prod = PROD_W'($signed(value)) * PROD_W'($signed({1'b0, size}));
   assign quot = prod[PROD_W-1:12];

   // negative gives zero, overflow saturates
   always_comb begin
      if (prod[PROD_W-1]) begin
         scaled = '0;
      end else if (|quot[PROD_W-13:mtsd_pkg::POS_W]) begin
         scaled = '1;
      end else begin
         scaled = quot[mtsd_pkg::POS_W-1:0];
      end
   end

endmodule

// File: rtl/mtsd_slot_state.sv
// Per-slot coordinates and pending marks, current slot, and report logic
module mtsd_slot_state #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  mtsd_pkg::event_type          evt,
   input  logic [mtsd_pkg::SIZE_W-1:0]  x_size,
   input  logic [mtsd_pkg::SIZE_W-1:0]  y_size,
   output mtsd_pkg::report_type         report
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [IDX_W-1:0]              cur_ff, cur_in;
   logic [mtsd_pkg::POS_W-1:0]    slot_x_ff [NUM_SLOTS];
   logic [mtsd_pkg::POS_W-1:0]    slot_y_ff [NUM_SLOTS];
   logic [1:0]                    slot_pend_ff [NUM_SLOTS];

   logic                          is_abs, is_syn;
   logic                          slot_ok;
   logic [1:0]                    pend_cur;
   logic [mtsd_pkg::SIZE_W-1:0]   size_sel;
   logic [mtsd_pkg::POS_W-1:0]    scaled;
   logic                          x_we, y_we, pend_we, cur_we, flush;
   logic [1:0]                    pend_in;
   logic [IDX_W+2:0]              cur_ext;

   assign is_abs   = (evt.ev_type == mtsd_pkg::TYPE_ABS);
   assign is_syn   = (evt.ev_type == mtsd_pkg::TYPE_SYN);
   assign slot_ok  = !evt.ev_value[31] && (evt.ev_value < 32'(NUM_SLOTS));
   assign pend_cur = slot_pend_ff[cur_ff];
   assign cur_ext  = {3'b000, cur_ff};

   // one multiplier shared by both axes
   assign size_sel = (evt.ev_code == mtsd_pkg::CODE_POSX) ? x_size : y_size;

   mtsd_scale u_scale (
      .value  (evt.ev_value),
      .size   (size_sel),
      .scaled (scaled)
   );

   // decode the event into slot updates and a report
   always_comb begin
      x_we    = 1'b0;
      y_we    = 1'b0;
      pend_we = 1'b0;
      pend_in = mtsd_pkg::PEND_NONE;
      cur_we  = 1'b0;
      cur_in  = evt.ev_value[IDX_W-1:0];
      flush   = 1'b0;
      report.hit    = 1'b0;
      report.kind   = mtsd_pkg::KIND_MOVE;
      report.pos_x  = slot_x_ff[cur_ff];
      report.pos_y  = slot_y_ff[cur_ff];
      report.finger = cur_ext[mtsd_pkg::FINGER_W-1:0];
      if (is_abs) begin
         unique case (evt.ev_code)
            mtsd_pkg::CODE_SLOT: begin
               if (slot_ok) begin
                  cur_we = 1'b1;
                  flush  = 1'b1;
               end
            end
            mtsd_pkg::CODE_TRACK: begin
               pend_we = 1'b1;
               if (evt.ev_value == mtsd_pkg::TRACK_RELEASE) begin
                  pend_in     = mtsd_pkg::PEND_NONE;
                  report.hit  = 1'b1;
                  report.kind = mtsd_pkg::KIND_RELEASE;
               end else begin
                  pend_in = mtsd_pkg::PEND_PRESS;
               end
            end
            mtsd_pkg::CODE_POSX, mtsd_pkg::CODE_POSY: begin
               x_we    = (evt.ev_code == mtsd_pkg::CODE_POSX);
               y_we    = (evt.ev_code == mtsd_pkg::CODE_POSY);
               pend_we = 1'b1;
               pend_in = (pend_cur == mtsd_pkg::PEND_PRESS) ? mtsd_pkg::PEND_PRESS
                                                            : mtsd_pkg::PEND_MOVE;
            end
            default: ;
         endcase
      end else if (is_syn && evt.ev_code == mtsd_pkg::CODE_REPORT) begin
         flush = 1'b1;
      end
      // flush reports and clears whatever is pending on the old slot
      if (flush && pend_cur != mtsd_pkg::PEND_NONE) begin
         report.hit  = 1'b1;
         report.kind = (pend_cur == mtsd_pkg::PEND_PRESS) ? mtsd_pkg::KIND_PRESS
                                                          : mtsd_pkg::KIND_MOVE;
         pend_we     = 1'b1;
         pend_in     = mtsd_pkg::PEND_NONE;
      end
   end

   // slot store
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_x_ff[i]    <= '0;
            slot_y_ff[i]    <= '0;
            slot_pend_ff[i] <= mtsd_pkg::PEND_NONE;
         end
      end else if (update) begin
         if (cur_we)  cur_ff                <= cur_in;
         if (x_we)    slot_x_ff[cur_ff]     <= scaled;
         if (y_we)    slot_y_ff[cur_ff]     <= scaled;
         if (pend_we) slot_pend_ff[cur_ff]  <= pend_in;
      end
   end

endmodule

// File: bench/touch_report_checker.sv
`timescale 1ns / 100ps

// Watches the event, report and register channels of the slot decoder, keeps its own
// copy of the slot tables and compares every report transfer with the oldest one owed.
module touch_report_checker #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   output int          mismatches,
   output int          reports_owed
);

   typedef struct packed {
      logic [1:0]                    kind;
      logic [mtsd_pkg::POS_W-1:0]    pos_x;
      logic [mtsd_pkg::POS_W-1:0]    pos_y;
      logic [mtsd_pkg::FINGER_W-1:0] finger;
   } touch_report_type;

   touch_report_type            reports_due[$];
   logic [mtsd_pkg::SIZE_W-1:0] screen_w;
   logic [mtsd_pkg::SIZE_W-1:0] screen_h;
   int                          active_slot;
   logic [mtsd_pkg::POS_W-1:0]  slot_x [NUM_SLOTS];
   logic [mtsd_pkg::POS_W-1:0]  slot_y [NUM_SLOTS];
   logic [1:0]                  slot_mark [NUM_SLOTS];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // raw position times screen size, divided by 4096, clamped to 0..65535
   function automatic logic [mtsd_pkg::POS_W-1:0] scale_axis(
      input logic [31:0] raw, input logic [mtsd_pkg::SIZE_W-1:0] size);
      longint product;
      product = longint'($signed(raw)) * longint'(size);
      if (product < 0)
         return '0;
      product = product >>> 12;
      if (product > 65535)
         return '1;
      return product[mtsd_pkg::POS_W-1:0];
   endfunction

   task automatic queue_report(input logic [1:0] kind, input int slot);
      reports_due.push_back({kind, slot_x[slot], slot_y[slot],
                             slot[mtsd_pkg::FINGER_W-1:0]});
   endtask

   // report and clear whatever is pending on a slot
   task automatic flush_slot(input int slot);
      if (slot_mark[slot] != mtsd_pkg::PEND_NONE) begin
         queue_report((slot_mark[slot] == mtsd_pkg::PEND_PRESS) ? mtsd_pkg::KIND_PRESS
                                                                : mtsd_pkg::KIND_MOVE, slot);
         slot_mark[slot] = mtsd_pkg::PEND_NONE;
      end
   endtask

   task automatic decode_touch_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                                     input logic [31:0] ev_value);
      int                 slot;
      logic signed [31:0] val;
      slot = active_slot;
      val  = ev_value;
      if (ev_type == mtsd_pkg::TYPE_ABS) begin
         if (ev_code == mtsd_pkg::CODE_SLOT) begin
            // out-of-range or negative slot numbers are dropped
            if (val >= 0 && val < NUM_SLOTS) begin
               active_slot = val;
               flush_slot(slot);
            end
         end else if (ev_code == mtsd_pkg::CODE_TRACK) begin
            if (ev_value == mtsd_pkg::TRACK_RELEASE) begin
               slot_mark[slot] = mtsd_pkg::PEND_NONE;
               queue_report(mtsd_pkg::KIND_RELEASE, slot);
            end else begin
               slot_mark[slot] = mtsd_pkg::PEND_PRESS;
            end
         end else if (ev_code == mtsd_pkg::CODE_POSX || ev_code == mtsd_pkg::CODE_POSY) begin
            if (ev_code == mtsd_pkg::CODE_POSX)
               slot_x[slot] = scale_axis(ev_value, screen_w);
            else
               slot_y[slot] = scale_axis(ev_value, screen_h);
            if (slot_mark[slot] != mtsd_pkg::PEND_PRESS)
               slot_mark[slot] = mtsd_pkg::PEND_MOVE;
         end
      end else if (ev_type == mtsd_pkg::TYPE_SYN && ev_code == mtsd_pkg::CODE_REPORT) begin
         flush_slot(active_slot);
      end
   endtask

   always @(posedge clock) begin : watch
      touch_report_type want;
      if (reset) begin
         reports_due.delete();
         screen_w = mtsd_pkg::WIDTH_RESET;
         screen_h = mtsd_pkg::HEIGHT_RESET;
         active_slot = 0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_x[i]    = '0;
            slot_y[i]    = '0;
            slot_mark[i] = mtsd_pkg::PEND_NONE;
         end
         mismatches = 0;
      end else begin
         // report side: compare with the oldest report owed
         if (rsp_tvalid && rsp_tready) begin
            if (reports_due.size() == 0) begin
               report_mismatch("report transfer with none owed", rsp_tdata, 0);
            end else begin
               want = reports_due.pop_front();
               if (rsp_tuser != want.kind)
                  report_mismatch("touch kind", rsp_tuser, want.kind);
               if (rsp_tdata[15:0] != want.pos_x)
                  report_mismatch("pos x", rsp_tdata[15:0], want.pos_x);
               if (rsp_tdata[31:16] != want.pos_y)
                  report_mismatch("pos y", rsp_tdata[31:16], want.pos_y);
               if (rsp_tdata[34:32] != want.finger)
                  report_mismatch("finger index", rsp_tdata[34:32], want.finger);
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == mtsd_pkg::CSR_SCREEN_WIDTH)
               screen_w = csr_data;
            else if (csr_index == mtsd_pkg::CSR_SCREEN_HEIGHT)
               screen_h = csr_data;
         end
         // event side
         if (req_tvalid && req_tready)
            decode_touch_event(req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]);
      end
      reports_owed <= reports_due.size();
   end

endmodule

// File: bench/tb_multitouch_slot_event_decoder_core.sv
`timescale 1ns / 100ps

module tb_multitouch_slot_event_decoder_core;

   localparam int NUM_SLOTS    = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;

   // codes the block must ignore
   localparam logic [15:0] TYPE_OTHER = 16'h0001;
   localparam logic [15:0] CODE_OTHER = 16'hffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = mtsd_pkg::CSR_SCREEN_WIDTH;
   logic [12:0] csr_data = '0;

   int   mismatches;
   int   reports_owed;
   int   events_sent = 0;
   int   cycle_count = 0;
   int   ready_hold = 0;
   logic calm = 1'b1;

   always #2 clock = ~clock;

   multitouch_slot_event_decoder_core #(.NUM_SLOTS(NUM_SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   touch_report_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .reports_owed (reports_owed)
   );

   // report sink: after each transfer outside a calm stretch, hold ready low for a random stretch that may be empty
   always @(posedge clock) begin : rsp_sink
      int hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= (ready_hold == 1);
      end else if (rsp_tvalid && rsp_tready && !calm) begin
         hold = $urandom_range(0, 15);
         ready_hold <= hold;
         rsp_tready <= (hold == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR cycle limit reached with %0d reports owed", reports_owed);
         $display("Verification failed");
         $finish;
      end
   end

   // one event transfer, after a random gap unless in a calm stretch
   task automatic send_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                             input logic [31:0] ev_value, input bit counted);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ev_value, ev_code, ev_type};
      do @(posedge clock); while (!req_tready);
      if (counted)
         events_sent++;
   endtask

   // stop sending and let every owed report and any event in flight drain
   task automatic quiet_down();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen(input logic [12:0] width, input logic [12:0] height);
      quiet_down();
      csr_valid <= 1'b1;
      csr_index <= mtsd_pkg::CSR_SCREEN_WIDTH;
      csr_data  <= width;
      do @(posedge clock); while (!csr_ready);
      csr_index <= mtsd_pkg::CSR_SCREEN_HEIGHT;
      csr_data  <= height;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly in-range 12-bit positions, sometimes any 32-bit value
   function automatic logic [31:0] raw_position();
      if ($urandom_range(0, 7) == 0)
         return $urandom;
      return $urandom_range(0, 4095);
   endfunction

   // random traffic: mostly well-formed frames, some noise and stray events
   task automatic run_phase(input int quota);
      int          first;
      int          fingers;
      logic [15:0] code;
      first = events_sent;
      while (events_sent - first < quota) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 4) != 0) begin
            // frame: a few fingers, each selected, maybe touched or lifted, maybe moved, then mostly a sync
            fingers = $urandom_range(1, 3);
            repeat (fingers) begin
               send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT,
                          $urandom_range(0, NUM_SLOTS - 1), 1'b1);
               case ($urandom_range(0, 3))
                  0: send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK,
                                $urandom_range(0, 65535), 1'b1);
                  1: send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK,
                                mtsd_pkg::TRACK_RELEASE, 1'b1);
                  default: ;
               endcase
               if ($urandom_range(0, 3) != 0)
                  send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSX, raw_position(), 1'b1);
               if ($urandom_range(0, 3) != 0)
                  send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSY, raw_position(), 1'b1);
            end
            if ($urandom_range(0, 7) != 0)
               send_event(mtsd_pkg::TYPE_SYN, mtsd_pkg::CODE_REPORT, $urandom, 1'b1);
         end else begin
            case ($urandom_range(0, 4))
               0: send_event(16'($urandom), 16'($urandom), $urandom, 1'b0);
               1: send_event(mtsd_pkg::TYPE_ABS, 16'($urandom), $urandom, 1'b0);
               2: begin
                  if ($urandom_range(0, 1) != 0)
                     send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT,
                                $urandom_range(NUM_SLOTS, 65535), 1'b0);
                  else
                     send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT,
                                {1'b1, 31'($urandom)}, 1'b0);
               end
               3: send_event(mtsd_pkg::TYPE_SYN, 16'($urandom), $urandom, 1'b0);
               default: begin
                  case ($urandom_range(0, 4))
                     0: code = mtsd_pkg::CODE_SLOT;
                     1: code = mtsd_pkg::CODE_TRACK;
                     2: code = mtsd_pkg::CODE_POSX;
                     3: code = mtsd_pkg::CODE_POSY;
                     default: code = mtsd_pkg::CODE_REPORT;
                  endcase
                  send_event(($urandom_range(0, 1) != 0) ? mtsd_pkg::TYPE_ABS
                                                         : mtsd_pkg::TYPE_SYN,
                             code, $urandom, 1'b1);
               end
            endcase
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset screen size 800 x 480
      send_event(mtsd_pkg::TYPE_SYN, mtsd_pkg::CODE_REPORT, 32'd0, 1'b1);  // nothing pending
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK, 32'd5, 1'b1);   // press on slot 0
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSX, 32'd4095, 1'b1);
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSY, 32'd0, 1'b1);
      send_event(mtsd_pkg::TYPE_SYN, mtsd_pkg::CODE_REPORT, 32'd0, 1'b1);  // press reported
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSX, 32'hffff_ffff, 1'b1); // clamps to 0
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSY, 32'h7fff_ffff, 1'b1); // saturates
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT, 32'd7, 1'b1);    // flushes slot 0
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK, 32'h7fff_ffff, 1'b1);
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT, 32'd7, 1'b1);    // same slot flushes
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT, NUM_SLOTS, 1'b1); // out of range
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT, 32'h8000_0000, 1'b1); // negative
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT, 32'hffff_ffff, 1'b1);
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK, mtsd_pkg::TRACK_RELEASE, 1'b1);
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK, 32'h8000_0000, 1'b1); // a press
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_POSX, 32'h8000_0000, 1'b1); // press stays
      send_event(mtsd_pkg::TYPE_SYN, CODE_OTHER, 32'd0, 1'b1);
      send_event(16'hffff, mtsd_pkg::CODE_SLOT, 32'd3, 1'b1);
      send_event(TYPE_OTHER, mtsd_pkg::CODE_REPORT, 32'd0, 1'b1);
      send_event(mtsd_pkg::TYPE_ABS, CODE_OTHER, 32'hffff_ffff, 1'b1);
      send_event(mtsd_pkg::TYPE_SYN, mtsd_pkg::CODE_REPORT, 32'hffff_ffff, 1'b1); // slot 7
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_SLOT, 32'd0, 1'b1);    // nothing left
      send_event(mtsd_pkg::TYPE_ABS, mtsd_pkg::CODE_TRACK, mtsd_pkg::TRACK_RELEASE, 1'b1);

      run_phase(230);
      write_screen(13'd1, 13'd4096);
      run_phase(200);
      write_screen(13'd4096, 13'd1);
      run_phase(200);
      write_screen(13'd0, 13'd8191);
      run_phase(200);
      write_screen(13'd8191, 13'd0);
      run_phase(200);
      write_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      run_phase(200);

      calm = 1'b1;
      quiet_down();
      if (mismatches == 0 && reports_owed == 0) begin
         $display("Verification passed");
      end else begin
         if (reports_owed != 0)
            $display("ERROR %0d reports never arrived", reports_owed);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
